FILE: src/kfcm_pkg.sv
// Package for the keyed record queue with source-class majority.
// Holds the record and result layouts, command and class codes, and the class lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kfcm_pkg;

    // Record as it is stored and as it arrives on the input tdata (id in the lowest bits).
    typedef struct packed {
        logic [31:0] arrive;
        logic [15:0] run_time;
        logic [15:0] len;
        logic [7:0]  dest;
        logic [7:0]  source;
        logic [15:0] id;
    } t_rec;

    // Result layout on the output tdata, ok in bit 0.
    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  top_source;
        logic [19:0] held_time_sum;
        logic [4:0]  held_count;
        t_rec        rec;
        logic        ok;
    } t_res;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } t_cls;

    // Tally update request from the sequencer to the tally unit.
    typedef struct packed {
        logic inc;
        logic dec;
        t_cls cls;
    } t_tally_upd;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_F = 8'h46;

    localparam logic [1:0] CLS_A = 2'd0;
    localparam logic [1:0] CLS_B = 2'd1;
    localparam logic [1:0] CLS_E = 2'd2;
    localparam logic [1:0] CLS_F = 2'd3;

    localparam logic [2:0] TOP_EMPTY = 3'd0;
    localparam logic [2:0] TOP_A     = 3'd1;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    function automatic t_cls class_of(input logic [7:0] src);
        t_cls c;
        c.hit = 1'b1;
        case (src)
            CH_A:    c.idx = CLS_A;
            CH_B:    c.idx = CLS_B;
            CH_E:    c.idx = CLS_E;
            CH_F:    c.idx = CLS_F;
            default: begin
                c.hit = 1'b0;
                c.idx = CLS_A;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/kfcm_store.sv
// Record store: one write port and one read port with registered read data.
// Depends on kfcm_pkg for the record layout.
`timescale 1ns / 1ps
`default_nettype none

module kfcm_store #(
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  kfcm_pkg::t_rec            i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output kfcm_pkg::t_rec            o_rdata
);

    kfcm_pkg::t_rec r_mem [DEPTH];
    kfcm_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/kfcm_tally.sv
// Per-class counters for sources A, B, E and F and the majority pick.
// Depends on kfcm_pkg for class codes and the update request.
`timescale 1ns / 1ps
`default_nettype none

module kfcm_tally #(
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  kfcm_pkg::t_tally_upd    i_upd,
    input  wire                     i_empty,
    output logic [2:0]              o_top
);

    localparam int TW = $clog2(DEPTH + 1);

    logic [TW-1:0] r_tally [4];
    logic [1:0]    w_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tally[k] <= '0;
            end
        end else if (i_upd.cls.hit) begin
            if (i_upd.inc) begin
                r_tally[i_upd.cls.idx] <= r_tally[i_upd.cls.idx] + TW'(1);
            end else if (i_upd.dec && (r_tally[i_upd.cls.idx] != '0)) begin
                r_tally[i_upd.cls.idx] <= r_tally[i_upd.cls.idx] - TW'(1);
            end
        end
    end

    // Strictly greater wins, so earlier classes keep ties.
    always_comb begin
        w_best = kfcm_pkg::CLS_A;
        if (r_tally[1] > r_tally[w_best]) w_best = kfcm_pkg::CLS_B;
        if (r_tally[2] > r_tally[w_best]) w_best = kfcm_pkg::CLS_E;
        if (r_tally[3] > r_tally[w_best]) w_best = kfcm_pkg::CLS_F;
        if (i_empty) begin
            o_top = kfcm_pkg::TOP_EMPTY;
        end else begin
            o_top = 3'(w_best) + kfcm_pkg::TOP_A;
        end
    end

endmodule

`default_nettype wire

FILE: src/kfcm_ctrl.sv
// Sequencer: accepts commands, walks the store for keyed search and compaction,
// keeps count, duration sum and limit, and holds the output register.
// Depends on kfcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kfcm_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  kfcm_pkg::t_rec              i_rec,
    input  wire                         i_cmd,
    input  wire                         i_cfg_we,
    input  wire [4:0]                   i_cfg_wdata,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output kfcm_pkg::t_res              o_res,
    output logic                        o_mem_we,
    output logic [$clog2(DEPTH)-1:0]    o_mem_waddr,
    output kfcm_pkg::t_rec              o_mem_wdata,
    output logic                        o_mem_re,
    output logic [$clog2(DEPTH)-1:0]    o_mem_raddr,
    input  kfcm_pkg::t_rec              i_mem_rdata,
    output kfcm_pkg::t_tally_upd        o_tally_upd,
    output logic                        o_empty,
    input  wire [2:0]                   i_top
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [FW-1:0]   r_fill;
    logic [20:0]     r_sum;
    logic [4:0]      r_limit;
    logic [7:0]      r_key;
    logic [FW-1:0]   r_rd_idx;
    logic            r_pend;
    logic [IW-1:0]   r_pend_idx;
    logic            r_ok;
    kfcm_pkg::t_rec  r_rec;
    logic            r_out_valid;
    kfcm_pkg::t_res  r_out;

    logic [FW-1:0]   w_lim;
    logic            w_accept;
    logic            w_enq_ok;
    logic            w_issue;
    logic            w_hit;
    logic            w_walk_end;
    logic            w_out_load;

    always_comb begin
        if ((r_limit == '0) || (32'(r_limit) > 32'(DEPTH))) begin
            w_lim = FW'(DEPTH);
        end else begin
            w_lim = FW'(r_limit);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_enq_ok   = w_accept && (i_cmd == kfcm_pkg::CMD_ENQ) && (r_fill < w_lim);

    // The walk compares: index against fill, then key against the fetched source.
    assign w_issue    = (r_rd_idx < r_fill);
    assign w_hit      = r_pend && (i_mem_rdata.source == r_key);
    assign w_walk_end = !w_issue && !r_pend;

    // A finished result moves into the output register once that register is free.
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fill[IW-1:0];
        o_mem_wdata = i_rec;
        if (w_enq_ok) begin
            o_mem_we = 1'b1;
        end else if ((r_state == S_SHIFT) && r_pend) begin
            // Each fetched record moves down one slot.
            o_mem_we    = 1'b1;
            o_mem_waddr = IW'(r_pend_idx - IW'(1));
            o_mem_wdata = i_mem_rdata;
        end
    end

    assign o_mem_re    = ((r_state == S_SRCH) || (r_state == S_SHIFT)) && w_issue;
    assign o_mem_raddr = r_rd_idx[IW-1:0];

    always_comb begin
        o_tally_upd.inc = w_enq_ok;
        o_tally_upd.dec = (r_state == S_SHIFT) && w_walk_end;
        if (w_enq_ok) begin
            o_tally_upd.cls = kfcm_pkg::class_of(i_rec.source);
        end else begin
            o_tally_upd.cls = kfcm_pkg::class_of(r_key);
        end
    end

    assign o_empty    = (r_fill == '0);
    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_limit     <= kfcm_pkg::LIMIT_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key    <= i_rec.source;
                        r_ok     <= w_enq_ok;
                        r_rec    <= '0;
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        if (i_cmd == kfcm_pkg::CMD_ENQ) begin
                            if (w_enq_ok) begin
                                r_fill <= r_fill + FW'(1);
                                r_sum  <= r_sum + 21'(i_rec.run_time);
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (w_hit) begin
                        r_ok     <= 1'b1;
                        r_rec    <= i_mem_rdata;
                        r_rd_idx <= FW'(r_pend_idx) + FW'(1);
                        r_pend   <= 1'b0;
                        r_state  <= S_SHIFT;
                    end else begin
                        if (w_issue) begin
                            r_rd_idx   <= r_rd_idx + FW'(1);
                            r_pend_idx <= r_rd_idx[IW-1:0];
                        end
                        r_pend <= w_issue;
                        if (w_walk_end) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    if (w_issue) begin
                        r_rd_idx   <= r_rd_idx + FW'(1);
                        r_pend_idx <= r_rd_idx[IW-1:0];
                    end
                    r_pend <= w_issue;
                    if (w_walk_end) begin
                        r_fill  <= r_fill - FW'(1);
                        r_sum   <= r_sum - 21'(r_rec.run_time);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out.pad           <= '0;
                        r_out.top_source    <= i_top;
                        r_out.held_time_sum <= r_sum[19:0];
                        r_out.held_count    <= 5'(r_fill);
                        r_out.rec           <= r_rec;
                        r_out.ok            <= r_ok;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/keyed_fifo_with_class_majority.sv
// Top level of the keyed record queue with source-class majority.
// Instantiates kfcm_ctrl, kfcm_store and kfcm_tally; uses kfcm_pkg.
//
// Records go in on the slave stream (tuser 0 appends, tuser 1 removes the oldest record
// whose source equals the key in tdata) and every transfer yields one result transfer
// carrying the removed record, the count and duration sum held afterwards, and the most
// common of sources A, B, E and F. The block takes one item at a time. A keyed removal
// searches the store and, on a match, compacts the order behind the removed record; the
// search and the compaction both walk the store through its single read port, one entry
// per cycle. A finished result sits in an output register, so the next item is taken
// while it waits; that next item holds in its done state until the waiting result has
// been transferred. The queue limit is written through i_cfg_we; the user must write it
// only while the block is idle, which the block itself does not enforce. Zero or a
// value above DEPTH means DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module keyed_fifo_with_class_majority #(
    parameter int DEPTH = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // id[15:0], source[23:16], dest[31:24], len[47:32], run_time[63:48], arrive[95:64]
    input  wire [95:0]   i_s_tdata,
    // cmd[0]
    input  wire          i_s_tuser,
    input  wire          i_cfg_we,
    input  wire [4:0]    i_cfg_wdata,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // ok[0], id[16:1], source[24:17], dest[32:25], len[48:33], run_time[64:49],
    // arrive[96:65], held_count[101:97], held_time_sum[121:102], top_source[124:122],
    // zero[127:125]
    output logic [127:0] o_m_tdata
);

    localparam int IW = $clog2(DEPTH);

    logic                     w_mem_we;
    logic [IW-1:0]            w_mem_waddr;
    kfcm_pkg::t_rec           w_mem_wdata;
    logic                     w_mem_re;
    logic [IW-1:0]            w_mem_raddr;
    kfcm_pkg::t_rec           w_mem_rdata;
    kfcm_pkg::t_tally_upd     w_tally_upd;
    logic                     w_empty;
    logic [2:0]               w_top;
    kfcm_pkg::t_res           w_res;

    kfcm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_rec       (kfcm_pkg::t_rec'(i_s_tdata)),
        .i_cmd       (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_tally_upd (w_tally_upd),
        .o_empty     (w_empty),
        .i_top       (w_top)
    );

    kfcm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    kfcm_tally #(
        .DEPTH (DEPTH)
    ) u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_tally_upd),
        .i_empty (w_empty),
        .o_top   (w_top)
    );

    assign o_m_tdata = 128'(w_res);

endmodule

`default_nettype wire

FILE: src/kfcm_checker.sv
// Port-level checks for keyed_fifo_with_class_majority, attached by the bind below.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module kfcm_checker #(
    parameter int DEPTH = 16
) (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_s_tvalid,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [127:0] o_m_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in progress");

    // A failed step reports no record.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[96:1] == '0))
        else $error("record fields set on a failed step");

    // The majority code is empty exactly when the queue is empty.
    a_top_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[124:122] <= 3'd4) && ((DEPTH >= 32) ||
            ((o_m_tdata[124:122] == 3'd0) == (o_m_tdata[101:97] == 5'd0)))))
        else $error("majority code disagrees with count");

endmodule

bind keyed_fifo_with_class_majority kfcm_checker #(
    .DEPTH (DEPTH)
) u_kfcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

`default_nettype wire
